>>> src/lat_pkg.sv
// Shared types, constants and codes for the login attempt throttle block.
package lat_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    localparam logic [39:0] TOTAL_MAX = 40'hFF_FFFF_FFFF;
    localparam logic [31:0] ATT_MAX = 32'hFFFF_FFFF;
    localparam logic [63:0] TIME_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [31:0] MAPPED_WORD = 32'h0000_FFFF;
    localparam logic [17:0] HEADER_BYTES = 18'd10;
    localparam logic [17:0] V6_ADDR_BYTES = 18'd32;
    localparam logic [17:0] V4_ADDR_BYTES = 18'd8;

    // configuration register indexes
    localparam logic [1:0] REG_ATTEMPT_LIMIT = 2'd0;
    localparam logic [1:0] REG_SIZE_LIMIT = 2'd1;
    localparam logic [1:0] REG_HOLDBACK_MS = 2'd2;
    localparam logic [1:0] REG_KEEP_CRED = 2'd3;

    localparam logic [31:0] RST_ATTEMPT_LIMIT = 32'd5;
    localparam logic [31:0] RST_SIZE_LIMIT = 32'd4194304;
    localparam logic [31:0] RST_HOLDBACK_MS = 32'd120000;

    // head operations
    localparam logic [1:0] OP_PASS = 2'd0;
    localparam logic [1:0] OP_HIT = 2'd1;
    localparam logic [1:0] OP_NEW = 2'd2;
    localparam logic [1:0] OP_CLEAN = 2'd3;

    localparam logic [1:0] SEND_NONE = 2'd0;
    localparam logic [1:0] SEND_REQ = 2'd1;
    localparam logic [1:0] SEND_FORCE = 2'd2;

    typedef struct packed {
        logic        mode;
        logic [63:0] now_ms;
        logic [7:0]  srv_code;
        logic        addr_is_v6;
        logic [63:0] remote_addr_high;
        logic [63:0] remote_addr_low;
        logic        is_login;
        logic [3:0]  plain_info_count;
        logic [15:0] plain_info_bytes;
        logic [3:0]  cred_info_count;
        logic [15:0] cred_info_bytes;
    } in_t;

    typedef struct packed {
        logic [1:0]  send_status;
        logic [39:0] pending_bytes;
        logic        attempts_hit;
        logic        table_full;
    } out_t;

    typedef struct packed {
        logic        valid;
        logic [7:0]  code;
        logic        is_v6;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [31:0] attempts;
        logic [63:0] hold_end;
    } entry_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  code;
        logic        is_v6;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [63:0] now;
        logic [63:0] hold_stop;
        logic [31:0] limit;
    } head_ctl_t;

    typedef struct packed {
        logic match;
        logic empty;
        logic trigger;
    } head_stat_t;

endpackage

>>> src/lat_cell.sv
// One table entry of the rotating entry ring.
module lat_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            shift,
    input  lat_pkg::entry_t d,
    output lat_pkg::entry_t q
);

    logic           valid_reg;
    lat_pkg::entry_t data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift)
        begin
            valid_reg <= d.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            data_reg <= d;
        end
    end

    always_comb
    begin
        q = data_reg;
        q.valid = valid_reg;
    end

endmodule

>>> src/lat_head.sv
// Entry processor at the head of the ring: match, update, insert, clean.
module lat_head (
    input  lat_pkg::entry_t     ent,
    input  lat_pkg::head_ctl_t  ctl,
    output lat_pkg::entry_t     ent_out,
    output lat_pkg::head_stat_t stat
);

    logic [31:0] att_inc;
    logic        match;

    assign match = ent.valid && (ent.code == ctl.code) && (ent.is_v6 == ctl.is_v6)
                   && (ent.addr_high == ctl.addr_high) && (ent.addr_low == ctl.addr_low);
    assign att_inc = (ent.attempts == lat_pkg::ATT_MAX) ? ent.attempts
                                                        : ent.attempts + 32'd1;

    always_comb
    begin
        ent_out = ent;
        stat.match = match;
        stat.empty = !ent.valid;
        stat.trigger = 1'b0;
        case (ctl.op)
            lat_pkg::OP_HIT:
            begin
                if (match)
                begin
                    ent_out.attempts = att_inc;
                    if ((att_inc >= ctl.limit) && (ent.hold_end <= ctl.now))
                    begin
                        stat.trigger = 1'b1;
                        ent_out.hold_end = ctl.hold_stop;
                    end
                end
            end
            lat_pkg::OP_NEW:
            begin
                ent_out.valid = 1'b1;
                ent_out.code = ctl.code;
                ent_out.is_v6 = ctl.is_v6;
                ent_out.addr_high = ctl.addr_high;
                ent_out.addr_low = ctl.addr_low;
                ent_out.attempts = 32'd1;
                ent_out.hold_end = '0;
                if (ctl.limit <= 32'd1)
                begin
                    stat.trigger = 1'b1;
                    ent_out.hold_end = ctl.hold_stop;
                end
            end
            lat_pkg::OP_CLEAN:
            begin
                if (ent.valid && (ent.hold_end > ctl.now))
                begin
                    ent_out.attempts = '0;
                end
                else
                begin
                    ent_out.valid = 1'b0;
                end
            end
            default:
            begin
                ent_out = ent;
            end
        endcase
    end

endmodule

>>> src/login_attempt_throttle_log_budget.sv
// Top level: login attempt throttle with pending log size budget.
//
// Usage:
//   An event transfer is taken at a rising edge with start high and busy low.
//   Each event yields exactly one result transfer: result_valid is high for one
//   cycle with the result struct; the receiver cannot hold it off.
//   Configuration writes (cfg_we, cfg_index, cfg_data) land at once; the user
//   must make them only while busy is low, the block does not enforce this.
// Structure:
//   The login key table is a ring of TABLE_ENTRIES cells that rotates by one
//   entry per cycle in a scan, insert or clean pass, past a single head
//   processor, which matches, updates, inserts or cleans the entry passing
//   through it. A position counter tracks which entry sits at the head, so a
//   pass may stop anywhere.
// Sequence (start edge to result strobe):
//   plain log event: add to the pending total, then output.
//   login: add, a full lap, a new key goes to a free slot if any, then output.
//   clean: one full lap of the ring, then output.
// Throughput:
//   One event at a time; busy drops in the cycle the result strobe is high,
//   so the next transfer can be taken at the edge that ends that cycle.
// Reset:
//   Table empty, pending total and attempts flag zero, registers at defaults.
module login_attempt_throttle_log_budget (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  lat_pkg::in_t   item,
    output logic           result_valid,
    output lat_pkg::out_t  result,
    input  logic           cfg_we,
    input  logic [1:0]     cfg_index,
    input  logic [31:0]    cfg_data
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ADD    = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_INSERT = 3'd3;
    localparam logic [2:0] ST_CLEAN  = 3'd4;
    localparam logic [2:0] ST_OUT    = 3'd5;

    // configuration
    logic [31:0] attempt_limit_reg;
    logic [31:0] size_limit_reg;
    logic [31:0] holdback_ms_reg;
    logic        keep_cred_reg;

    // control state
    logic [2:0]               state_reg, state_next;
    logic [lat_pkg::IDX_W-1:0] pos_reg, pos_next;
    logic [lat_pkg::IDX_W-1:0] cnt_reg, cnt_next;
    logic [lat_pkg::IDX_W-1:0] free_idx_reg, free_idx_next;
    logic                     free_any_reg, free_any_next;
    logic                     found_reg, found_next;
    logic                     full_reg, full_next;
    logic [39:0]              total_reg, total_next;
    logic                     flag_reg, flag_next;
    logic                     rvalid_reg;

    // job payload
    logic [17:0]   size_reg;
    logic          login_reg;
    lat_pkg::out_t result_reg;
    lat_pkg::head_ctl_t job_reg;

    // ring
    lat_pkg::entry_t     cell_q [lat_pkg::TABLE_ENTRIES];
    lat_pkg::entry_t     head_out;
    lat_pkg::head_ctl_t  head_ctl;
    lat_pkg::head_stat_t head_stat;
    logic                shift;

    logic        accept;
    logic        mapped, v6;
    logic [17:0] size_calc;
    logic [6:0]  pcnt5, ccnt5;
    logic [64:0] until_sum;
    logic [40:0] total_sum;
    logic [40:0] two_lim;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy = (state_reg != ST_IDLE);

    // address normalization: IPv4-mapped IPv6 becomes IPv4
    assign mapped = item.addr_is_v6 && (item.remote_addr_high == '0)
                    && (item.remote_addr_low[63:32] == lat_pkg::MAPPED_WORD);
    assign v6 = item.addr_is_v6 && !mapped;

    assign pcnt5 = {1'b0, item.plain_info_count, 2'b00} + {3'b000, item.plain_info_count};
    assign ccnt5 = {1'b0, item.cred_info_count, 2'b00} + {3'b000, item.cred_info_count};
    assign size_calc = lat_pkg::HEADER_BYTES
                       + (v6 ? lat_pkg::V6_ADDR_BYTES : lat_pkg::V4_ADDR_BYTES)
                       + {11'd0, pcnt5} + {2'd0, item.plain_info_bytes}
                       + (keep_cred_reg ? ({11'd0, ccnt5} + {2'd0, item.cred_info_bytes})
                                        : 18'd0);
    assign until_sum = {1'b0, item.now_ms} + {33'd0, holdback_ms_reg};

    assign total_sum = {1'b0, total_reg} + {23'd0, size_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attempt_limit_reg <= lat_pkg::RST_ATTEMPT_LIMIT;
            size_limit_reg <= lat_pkg::RST_SIZE_LIMIT;
            holdback_ms_reg <= lat_pkg::RST_HOLDBACK_MS;
            keep_cred_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lat_pkg::REG_ATTEMPT_LIMIT: attempt_limit_reg <= cfg_data;
                lat_pkg::REG_SIZE_LIMIT:    size_limit_reg <= cfg_data;
                lat_pkg::REG_HOLDBACK_MS:   holdback_ms_reg <= cfg_data;
                lat_pkg::REG_KEEP_CRED:     keep_cred_reg <= cfg_data[0];
                default:                    keep_cred_reg <= keep_cred_reg;
            endcase
        end
    end

    // job latch
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            size_reg <= size_calc;
            login_reg <= item.is_login;
            job_reg.code <= item.srv_code;
            job_reg.is_v6 <= v6;
            job_reg.addr_high <= v6 ? item.remote_addr_high : 64'd0;
            job_reg.addr_low <= v6 ? item.remote_addr_low
                                   : {32'd0, item.remote_addr_low[31:0]};
            job_reg.now <= item.now_ms;
            job_reg.hold_stop <= until_sum[64] ? lat_pkg::TIME_MAX : until_sum[63:0];
            job_reg.op <= lat_pkg::OP_PASS;
            job_reg.limit <= attempt_limit_reg;
        end
    end

    // head op selection
    always_comb
    begin
        head_ctl = job_reg;
        case (state_reg)
            ST_SCAN:   head_ctl.op = lat_pkg::OP_HIT;
            ST_CLEAN:  head_ctl.op = lat_pkg::OP_CLEAN;
            ST_INSERT: head_ctl.op = (pos_reg == free_idx_reg) ? lat_pkg::OP_NEW
                                                               : lat_pkg::OP_PASS;
            default:   head_ctl.op = lat_pkg::OP_PASS;
        endcase
    end

    lat_head u_head (
        .ent     (cell_q[0]),
        .ctl     (head_ctl),
        .ent_out (head_out),
        .stat    (head_stat)
    );

    assign shift = (state_reg == ST_SCAN) || (state_reg == ST_CLEAN)
                   || (state_reg == ST_INSERT);

    for (genvar k = 0; k < lat_pkg::TABLE_ENTRIES; k++)
    begin : g_ring
        if (k == lat_pkg::TABLE_ENTRIES - 1)
        begin : g_tail
            lat_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (shift),
                .d     (head_out),
                .q     (cell_q[k])
            );
        end
        else
        begin : g_mid
            lat_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (shift),
                .d     (cell_q[k+1]),
                .q     (cell_q[k])
            );
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        pos_next = pos_reg;
        cnt_next = cnt_reg;
        free_idx_next = free_idx_reg;
        free_any_next = free_any_reg;
        found_next = found_reg;
        full_next = full_reg;
        total_next = total_reg;
        flag_next = flag_reg;

        if (shift)
        begin
            pos_next = (pos_reg == lat_pkg::LAST_IDX) ? '0 : pos_reg + 1'b1;
            if (head_stat.trigger)
            begin
                flag_next = 1'b1;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    full_next = 1'b0;
                    found_next = 1'b0;
                    free_any_next = 1'b0;
                    cnt_next = '0;
                    if (item.mode)
                    begin
                        total_next = '0;
                        flag_next = 1'b0;
                        state_next = ST_CLEAN;
                    end
                    else
                    begin
                        state_next = ST_ADD;
                    end
                end
            end
            ST_ADD:
            begin
                total_next = total_sum[40] ? lat_pkg::TOTAL_MAX : total_sum[39:0];
                state_next = login_reg ? ST_SCAN : ST_OUT;
            end
            ST_SCAN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (head_stat.match)
                begin
                    found_next = 1'b1;
                end
                // lowest free index, the lap may start anywhere
                if (head_stat.empty && (!free_any_reg || (pos_reg < free_idx_reg)))
                begin
                    free_any_next = 1'b1;
                    free_idx_next = pos_reg;
                end
                if (cnt_reg == lat_pkg::LAST_IDX)
                begin
                    if (found_next)
                    begin
                        state_next = ST_OUT;
                    end
                    else if (free_any_next)
                    begin
                        state_next = ST_INSERT;
                    end
                    else
                    begin
                        full_next = 1'b1;
                        state_next = ST_OUT;
                    end
                end
            end
            ST_INSERT:
            begin
                if (pos_reg == free_idx_reg)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_CLEAN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == lat_pkg::LAST_IDX)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pos_reg <= '0;
            cnt_reg <= '0;
            free_idx_reg <= '0;
            free_any_reg <= 1'b0;
            found_reg <= 1'b0;
            full_reg <= 1'b0;
            total_reg <= '0;
            flag_reg <= 1'b0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg <= pos_next;
            cnt_reg <= cnt_next;
            free_idx_reg <= free_idx_next;
            free_any_reg <= free_any_next;
            found_reg <= found_next;
            full_reg <= full_next;
            total_reg <= total_next;
            flag_reg <= flag_next;
            rvalid_reg <= (state_reg == ST_OUT);
        end
    end

    // send status against the limit, twice the limit and the attempts flag, no wrap
    assign two_lim = {8'd0, size_limit_reg, 1'b0};

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT)
        begin
            if ({1'b0, total_reg} >= two_lim)
            begin
                result_reg.send_status <= lat_pkg::SEND_FORCE;
            end
            else if (flag_reg || (total_reg >= {8'd0, size_limit_reg}))
            begin
                result_reg.send_status <= lat_pkg::SEND_REQ;
            end
            else
            begin
                result_reg.send_status <= lat_pkg::SEND_NONE;
            end
            result_reg.pending_bytes <= total_reg;
            result_reg.attempts_hit <= flag_reg;
            result_reg.table_full <= full_reg;
        end
    end

    assign result_valid = rvalid_reg;
    assign result = result_reg;

endmodule
